@@ rtl/spqu_pkg.sv @@
`timescale 1ns / 1ps
package spqu_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_INSERT = 3'd0;
  localparam mode_t MODE_POP    = 3'd1;
  localparam mode_t MODE_PEEK   = 3'd2;
  localparam mode_t MODE_DELETE = 3'd3;
  localparam mode_t MODE_CHANGE = 3'd4;
  localparam mode_t MODE_LIST   = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pr;
    logic [15:0] tm;
  } ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic list_adv;
    logic sort_step;
    logic sort_phase;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic list_more;
    logic need_sort;
  } sts_t;

endpackage

@@ rtl/sorted_priority_queue_with_update.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_mode, in_entry_id, in_entry_priority, in_entry_time
// out       out_valid / out_ready out_found, out_id, out_priority, out_time,
//                                 out_status, out_last
//
// One item at a time: accept, an execute state, then its results, one per
// out handshake. Change priority then re-sorts by odd-even transposition
// over the cell row before the next item is taken.
// Opcodes six and seven pass through the execute state and give no result.
// Reset is synchronous, active low, and empties the queue.
module sorted_priority_queue_with_update import spqu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_entry_id,
  input  logic [7:0]  in_entry_priority,
  input  logic [15:0] in_entry_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [15:0] out_id,
  output logic [7:0]  out_priority,
  output logic [15:0] out_time,
  output logic [1:0]  out_status,
  output logic        out_last
);

  cmd_t cmd;
  sts_t sts;

  spqu_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spqu_dp #(.DEPTH(DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .in_entry_time     (in_entry_time),
    .out_found         (out_found),
    .out_id            (out_id),
    .out_priority      (out_priority),
    .out_time          (out_time),
    .out_status        (out_status),
    .out_last          (out_last)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item accepted while a result is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK)) else $error("entry with bad status");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid) else $error("result after last");
`endif

endmodule

@@ rtl/spqu_ctrl.sv @@
`timescale 1ns / 1ps
module spqu_ctrl import spqu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT, S_SORT} state_t;

  state_t        state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.sort_phase = cnt_r[0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.has_result) begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          priority if (sts.list_more) begin
            cmd.list_adv = 1'b1;
          end else if (sts.need_sort) begin
            out_valid_nxt = 1'b0;
            cnt_nxt       = '0;
            state_nxt     = S_SORT;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == IW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

@@ rtl/spqu_dp.sv @@
`timescale 1ns / 1ps
module spqu_dp import spqu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_entry_id,
  input  logic [7:0]  in_entry_priority,
  input  logic [15:0] in_entry_time,
  output logic        out_found,
  output logic [15:0] out_id,
  output logic [7:0]  out_priority,
  output logic [15:0] out_time,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ent_t          cell_r [DEPTH];
  ent_t          cell_nxt [DEPTH];
  logic [IW-1:0] tag_r [DEPTH];
  logic [IW-1:0] tag_nxt [DEPTH];
  ent_t          cell_up [DEPTH];
  ent_t          cell_dn [DEPTH];
  logic [IW-1:0] tag_up [DEPTH];
  logic [IW-1:0] tag_dn [DEPTH];

  logic [CW-1:0] occ_r, occ_nxt;
  mode_t         mode_r, mode_nxt;
  ent_t          req_r, req_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          srt_r, srt_nxt;

  logic          found_r, found_nxt;
  ent_t          oent_r, oent_nxt;
  status_t       ost_r, ost_nxt;
  logic          olast_r, olast_nxt;

  logic [DEPTH-1:0] valid, ahead, ahead_sh, match, seen, hit_le, better, sw, sw_sh;
  logic [DEPTH-1:0] valid_up;
  ent_t             sel;
  logic             any_match;
  logic [8:0]       list_n;

  for (genvar g = 0; g < DEPTH; g++) begin : g_nb
    if (g == 0) begin : g_first
      assign cell_dn[g] = cell_r[g];
      assign tag_dn[g]  = tag_r[g];
    end else begin : g_dn
      assign cell_dn[g] = cell_r[g-1];
      assign tag_dn[g]  = tag_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign cell_up[g] = cell_r[g];
      assign tag_up[g]  = tag_r[g];
    end else begin : g_up
      assign cell_up[g] = cell_r[g+1];
      assign tag_up[g]  = tag_r[g+1];
    end
  end

  // Per-cell compares; all cells look at their own entry in parallel.
  always_comb begin
    logic [DEPTH-1:0] below;
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = (CW'(i) < occ_r);
      ahead[i] = valid[i] && ((cell_r[i].pr > req_r.pr) ||
                 (cell_r[i].pr == req_r.pr && cell_r[i].tm < req_r.tm));
      match[i] = valid[i] && cell_r[i].id == req_r.id && cell_r[i].tm == req_r.tm;
      better[i] = (cell_up[i].pr > cell_r[i].pr) ||
                  (cell_up[i].pr == cell_r[i].pr && cell_up[i].tm < cell_r[i].tm) ||
                  (cell_up[i].pr == cell_r[i].pr && cell_up[i].tm == cell_r[i].tm &&
                   tag_up[i] > tag_r[i]);
    end
    valid_up = {1'b0, valid[DEPTH-1:1]};
    ahead_sh = {ahead[DEPTH-2:0], 1'b1};
    for (int i = 0; i < DEPTH; i++) begin
      below     = (DEPTH'(1) << i) - DEPTH'(1);
      seen[i]   = |(match & below);
      hit_le[i] = seen[i] | match[i];
      sw[i]     = (1'(i) == cmd.sort_phase) && valid_up[i] && better[i];
      if (match[i] && !seen[i]) begin
        sel = sel | cell_r[i];
      end
    end
    sw_sh     = {sw[DEPTH-2:0], 1'b0};
    any_match = |match;
    list_n    = (9'(occ_r) > 9'(MAX_RESULTS)) ? 9'(MAX_RESULTS) : 9'(occ_r);
  end

  always_comb begin
    cell_nxt  = cell_r;
    tag_nxt   = tag_r;
    occ_nxt   = occ_r;
    mode_nxt  = mode_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    srt_nxt   = srt_r;
    found_nxt = found_r;
    oent_nxt  = oent_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;

    if (cmd.capture) begin
      mode_nxt   = in_mode;
      req_nxt.id = in_entry_id;
      req_nxt.pr = in_entry_priority;
      req_nxt.tm = in_entry_time;
    end

    if (cmd.exec) begin
      found_nxt = 1'b0;
      oent_nxt  = '0;
      ost_nxt   = ST_OK;
      olast_nxt = 1'b1;
      srt_nxt   = 1'b0;
      idx_nxt   = '0;
      unique case (mode_r)
        MODE_INSERT: begin
          if (occ_r == CW'(DEPTH)) begin
            ost_nxt = ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (!ahead[i]) begin
                cell_nxt[i] = ahead_sh[i] ? req_r : cell_dn[i];
              end
            end
            occ_nxt = occ_r + 1'b1;
          end
        end
        MODE_POP, MODE_PEEK: begin
          if (occ_r == '0) begin
            ost_nxt = ST_EMPTY;
          end else begin
            found_nxt = 1'b1;
            oent_nxt  = cell_r[0];
            if (mode_r == MODE_POP) begin
              cell_nxt = cell_up;
              occ_nxt  = occ_r - 1'b1;
            end
          end
        end
        MODE_DELETE: begin
          if (!any_match) begin
            ost_nxt = ST_NOT_FOUND;
          end else begin
            found_nxt = 1'b1;
            oent_nxt  = sel;
            for (int i = 0; i < DEPTH; i++) begin
              if (hit_le[i]) begin
                cell_nxt[i] = cell_up[i];
              end
            end
            occ_nxt = occ_r - 1'b1;
          end
        end
        MODE_CHANGE: begin
          if (!any_match) begin
            ost_nxt = ST_NOT_FOUND;
          end else begin
            found_nxt   = 1'b1;
            oent_nxt    = sel;
            oent_nxt.pr = req_r.pr;
            srt_nxt     = 1'b1;
            // Old position breaks exact ties: later entries come out first.
            for (int i = 0; i < DEPTH; i++) begin
              tag_nxt[i] = IW'(i);
              if (match[i] && !seen[i]) begin
                cell_nxt[i].pr = req_r.pr;
              end
            end
          end
        end
        MODE_LIST: begin
          if (occ_r == '0) begin
            ost_nxt = ST_EMPTY;
          end else begin
            found_nxt = 1'b1;
            oent_nxt  = cell_r[0];
            olast_nxt = (list_n == 9'd1);
          end
        end
        default: ;
      endcase
    end

    if (cmd.list_adv) begin
      idx_nxt   = idx_r + 1'b1;
      oent_nxt  = cell_r[idx_r + 1'b1];
      olast_nxt = (9'(idx_r) + 9'd2 == list_n);
    end

    if (cmd.sort_step) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (sw[i]) begin
          cell_nxt[i] = cell_up[i];
          tag_nxt[i]  = tag_up[i];
        end else if (sw_sh[i]) begin
          cell_nxt[i] = cell_dn[i];
          tag_nxt[i]  = tag_dn[i];
        end
      end
    end
  end

  assign sts.has_result = (mode_r <= MODE_LIST);
  assign sts.list_more  = (mode_r == MODE_LIST) && (occ_r != '0) &&
                          (9'(idx_r) + 9'd1 < list_n);
  assign sts.need_sort  = srt_r;

  assign out_found    = found_r;
  assign out_id       = oent_r.id;
  assign out_priority = oent_r.pr;
  assign out_time     = oent_r.tm;
  assign out_status   = ost_r;
  assign out_last     = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      srt_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      srt_r <= srt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r  <= cell_nxt;
    tag_r   <= tag_nxt;
    mode_r  <= mode_nxt;
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    oent_r  <= oent_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

endmodule

@@ bench/sorted_priority_queue_with_update_tb.sv @@
`timescale 1ns / 1ps
module sorted_priority_queue_with_update_tb;
  import spqu_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic        found;
    logic [15:0] id;
    logic [7:0]  pr;
    logic [15:0] tm;
    logic [1:0]  status;
    logic        last;
  } qres_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [15:0] in_entry_id;
  logic [7:0]  in_entry_priority;
  logic [15:0] in_entry_time;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic [15:0] out_id;
  logic [7:0]  out_priority;
  logic [15:0] out_time;
  logic [1:0]  out_status;
  logic        out_last;

  sorted_priority_queue_with_update #(.DEPTH(DEPTH)) DUT (.*);

  // Shadow copy of the queue contents, front at index zero.
  ent_t   shadow_q[$];
  qres_t  pending_res[$];
  int     err_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     n_sent;
  int     n_checked;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic qres_t mk_res(logic f, ent_t e, status_t s, logic l);
    qres_t r;
    r.found = f;
    r.id = f ? e.id : 16'd0;
    r.pr = f ? e.pr : 8'd0;
    r.tm = f ? e.tm : 16'd0;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  function automatic int find_slot(ent_t q[$], logic [7:0] pr, logic [15:0] tm);
    int pos;
    pos = 0;
    while (pos < q.size() && (q[pos].pr > pr || (q[pos].pr == pr && q[pos].tm < tm)))
      pos++;
    return pos;
  endfunction

  function automatic int find_entry(logic [15:0] id, logic [15:0] tm);
    foreach (shadow_q[i])
      if (shadow_q[i].id == id && shadow_q[i].tm == tm)
        return i;
    return -1;
  endfunction

  task automatic predict_queue(mode_t m, logic [15:0] id, logic [7:0] pr, logic [15:0] tm);
    ent_t e;
    ent_t zero_e;
    ent_t old_q[$];
    int   pos;
    int   n;
    zero_e = '0;
    e.id = id;
    e.pr = pr;
    e.tm = tm;
    case (m)
      MODE_INSERT: begin
        if (shadow_q.size() >= DEPTH) begin
          pending_res.push_back(mk_res(1'b0, zero_e, ST_FULL, 1'b1));
        end else begin
          shadow_q.insert(find_slot(shadow_q, pr, tm), e);
          pending_res.push_back(mk_res(1'b0, zero_e, ST_OK, 1'b1));
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (shadow_q.size() == 0) begin
          pending_res.push_back(mk_res(1'b0, zero_e, ST_EMPTY, 1'b1));
        end else begin
          pending_res.push_back(mk_res(1'b1, shadow_q[0], ST_OK, 1'b1));
          if (m == MODE_POP) shadow_q.delete(0);
        end
      end
      MODE_DELETE: begin
        pos = find_entry(id, tm);
        if (pos < 0) begin
          pending_res.push_back(mk_res(1'b0, zero_e, ST_NOT_FOUND, 1'b1));
        end else begin
          pending_res.push_back(mk_res(1'b1, shadow_q[pos], ST_OK, 1'b1));
          shadow_q.delete(pos);
        end
      end
      MODE_CHANGE: begin
        pos = find_entry(id, tm);
        if (pos < 0) begin
          pending_res.push_back(mk_res(1'b0, zero_e, ST_NOT_FOUND, 1'b1));
        end else begin
          shadow_q[pos].pr = pr;
          pending_res.push_back(mk_res(1'b1, shadow_q[pos], ST_OK, 1'b1));
          // Re-insertion in old order reverses runs of identical keys.
          old_q = shadow_q;
          shadow_q.delete();
          foreach (old_q[i])
            shadow_q.insert(find_slot(shadow_q, old_q[i].pr, old_q[i].tm), old_q[i]);
        end
      end
      MODE_LIST: begin
        n = (shadow_q.size() < MAX_RESULTS) ? shadow_q.size() : MAX_RESULTS;
        if (n == 0)
          pending_res.push_back(mk_res(1'b0, zero_e, ST_EMPTY, 1'b1));
        for (int k = 0; k < n; k++)
          pending_res.push_back(mk_res(1'b1, shadow_q[k], ST_OK, k == n - 1));
      end
      default: ;
    endcase
  endtask

  // Valid stays high into the next item unless the sender idles first.
  task automatic send_item(mode_t m, logic [15:0] id, logic [7:0] pr, logic [15:0] tm);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_entry_id <= id;
    in_entry_priority <= pr;
    in_entry_time <= tm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue(m, id, pr, tm);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4 * DEPTH) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    qres_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pending_res.size() == 0) begin
        $error("result with nothing expected");
        err_count++;
      end else begin
        exp_r = pending_res.pop_front();
        if (out_found !== exp_r.found) begin
          $error("found exp %0d got %0d", exp_r.found, out_found); err_count++;
        end
        if (out_id !== exp_r.id) begin
          $error("out_id exp %0h got %0h", exp_r.id, out_id); err_count++;
        end
        if (out_priority !== exp_r.pr) begin
          $error("out_priority exp %0h got %0h", exp_r.pr, out_priority); err_count++;
        end
        if (out_time !== exp_r.tm) begin
          $error("out_time exp %0h got %0h", exp_r.tm, out_time); err_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_status); err_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_last); err_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(MODE_POP, 16'd0, 8'd0, 16'd0);
    send_item(MODE_PEEK, 16'd0, 8'd0, 16'd0);
    send_item(MODE_LIST, 16'd0, 8'd0, 16'd0);
    send_item(MODE_DELETE, 16'd1, 8'd0, 16'd1);
    send_item(MODE_CHANGE, 16'd1, 8'd0, 16'd1);
    send_item(MODE_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(MODE_INSERT, 16'h0000, 8'h00, 16'h0000);
    // Identical keys: the newer one goes in front.
    send_item(MODE_INSERT, 16'h1111, 8'h80, 16'h0100);
    send_item(MODE_INSERT, 16'h2222, 8'h80, 16'h0100);
    send_item(MODE_INSERT, 16'h3333, 8'h80, 16'h0100);
    send_item(MODE_LIST, 16'd0, 8'd0, 16'd0);
    send_item(MODE_CHANGE, 16'h0000, 8'h80, 16'h0000);
    send_item(MODE_LIST, 16'd0, 8'd0, 16'd0);
    send_item(MODE_DELETE, 16'h2222, 8'd0, 16'h0101);
    send_item(MODE_DELETE, 16'h2222, 8'd0, 16'h0100);
    send_item(MODE_PEEK, 16'd0, 8'd0, 16'd0);
    send_item(MODE_POP, 16'd0, 8'd0, 16'd0);
    send_item(3'd6, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(3'd7, 16'h0, 8'h0, 16'h0);
    for (int i = 0; i < DEPTH; i++)
      send_item(MODE_INSERT, 16'(i), 8'(i & 3), 16'(i));
    send_item(MODE_LIST, 16'd0, 8'd0, 16'd0);
    drain_results();
  endtask

  task automatic test_random(int n_items);
    mode_t       m;
    logic [15:0] id;
    logic [7:0]  pr;
    logic [15:0] tm;
    int          pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      m = (pick < 30) ? MODE_INSERT : (pick < 42) ? MODE_POP : (pick < 50) ? MODE_PEEK :
          (pick < 65) ? MODE_DELETE : (pick < 85) ? MODE_CHANGE : (pick < 95) ? MODE_LIST :
          mode_t'($urandom_range(7));
      id = 16'($urandom);
      pr = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom);
      tm = ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom);
      // Delete and change mostly target a held entry.
      if ((m == MODE_DELETE || m == MODE_CHANGE) && shadow_q.size() != 0 &&
          $urandom_range(3) != 0) begin
        pick = $urandom_range(shadow_q.size() - 1);
        id = shadow_q[pick].id;
        tm = shadow_q[pick].tm;
      end
      send_item(m, id, pr, tm);
      if (i == n_items / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    err_count = 0;
    n_sent = 0;
    n_checked = 0;
    send_idle_pct = 23;
    recv_idle_pct = 67;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_entry_id = '0;
    in_entry_priority = '0;
    in_entry_time = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100);
    send_idle_pct = 67;
    recv_idle_pct = 23;
    test_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100);
    $display("Sent %0d items over three idling profiles; checked %0d results.",
             n_sent, n_checked);
    if (err_count == 0 && pending_res.size() == 0) begin
      $display("PASS sorted_priority_queue_with_update");
    end else begin
      $display("FAIL sorted_priority_queue_with_update");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL sorted_priority_queue_with_update");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spqu_pkg.sv
rtl/spqu_ctrl.sv
rtl/spqu_dp.sv
rtl/sorted_priority_queue_with_update.sv
bench/sorted_priority_queue_with_update_tb.sv
